@@ rtl/greedy_interval_stall_allocator_macros.svh @@
// assertion macros for the greedy interval stall allocator
// used by the top level only, needs a signal named clock and one named reset in scope
`ifndef GREEDY_INTERVAL_STALL_ALLOCATOR_MACROS_SVH
`define GREEDY_INTERVAL_STALL_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define GISA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GISA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/gisa_pkg.sv @@
// shared types, constants and helpers of the greedy interval stall allocator
// no dependencies
package gisa_pkg;

   localparam int MAX_STALLS = 64;
   localparam int TIME_BITS  = 20;
   localparam int ID_BITS    = 7;

   localparam logic [ID_BITS-1:0] ONE_ID = ID_BITS'(1);
   localparam logic [ID_BITS-1:0] MAX_ID = ID_BITS'(MAX_STALLS);

   typedef struct packed {
      logic                 restart;
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] end_time;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] stall_id;
      logic [ID_BITS-1:0] stalls_in_use;
      logic               overflow;
   } rsp_type;

   // one stall entry of the sorted row
   typedef struct packed {
      logic                 valid;
      logic [TIME_BITS-1:0] busy_until;
      logic [ID_BITS-1:0]   id;
   } cell_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_REPLACE,
      OP_INSERT
   } op_type;

   // command broadcast to every cell
   typedef struct packed {
      op_type               op;
      logic [TIME_BITS-1:0] busy_until;
      logic [ID_BITS-1:0]   id;
   } cmd_type;

   // ordering by busy time, then stall id; empty entries sort last
   function automatic logic key_less(input cell_type c, input cmd_type k);
      return c.valid && ({c.busy_until, c.id} < {k.busy_until, k.id});
   endfunction

endpackage

@@ rtl/gisa_cell.sv @@
// one cell of the sorted stall row: holds one stall entry, shifts with its neighbors
// depends on gisa_pkg
module gisa_cell
   import gisa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     is_head,
   input  cmd_type  cmd,
   input  cell_type left_cell,
   input  logic     left_lt,
   input  cell_type right_cell,
   input  logic     right_lt,
   output cell_type cell_q,
   output logic     lt
);

   cell_type cell_ff;
   cell_type cell_in;
   cell_type new_cell;
   cell_type init_cell;

   assign lt       = key_less(cell_ff, cmd);
   assign new_cell = '{valid: 1'b1, busy_until: cmd.busy_until, id: cmd.id};
   assign init_cell = is_head ? cell_type'{valid: 1'b1, busy_until: '0, id: ONE_ID}
                              : cell_type'('0);
   assign cell_q   = cell_ff;

   always_comb begin
      cell_in = cell_ff;
      case (cmd.op)
         OP_CLEAR: begin
            cell_in = init_cell;
         end
         // head leaves, smaller keys move toward the head, new key drops in
         OP_REPLACE: begin
            if (right_lt) begin
               cell_in = right_cell;
            end else if (is_head || lt) begin
               cell_in = new_cell;
            end
         end
         // smaller keys stay, larger keys move away from the head
         OP_INSERT: begin
            if (!lt) begin
               if (is_head || left_lt) begin
                  cell_in = new_cell;
               end else begin
                  cell_in = left_cell;
               end
            end
         end
         default: begin
            cell_in = cell_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= init_cell;
      end else begin
         cell_ff <= cell_in;
      end
   end

endmodule

@@ rtl/greedy_interval_stall_allocator.sv @@
// top level of the greedy interval stall allocator: request decode, stall choice,
// sorted row of gisa_cell instances, result register; depends on gisa_pkg and the macros header
//
// Each request goes through an accept step and an execute step: in the cycle it is
// accepted the interval is checked against the head of a row of cells kept sorted by
// busy-until time and stall id, so the head always holds the earliest free stall; once
// the output register is free the whole row shifts by one place in parallel to take
// out the head and put the updated entry in order, or to add a newly opened stall. The
// result goes to an output register, and the next request is taken in the following
// cycle while that result may still wait. A restart bit clears the row in the
// accepting cycle, before the interval is placed. There is no clearing pass after reset.
`include "greedy_interval_stall_allocator_macros.svh"

module greedy_interval_stall_allocator
   import gisa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // pending row update and result of the request in flight
   cmd_type pend_cmd_ff, pend_cmd_in;
   rsp_type pend_rsp_ff, pend_rsp_in;
   logic [ID_BITS-1:0] open_count_ff, open_count_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic out_free;
   logic exec_go;

   // decision against the head of the row
   logic [TIME_BITS-1:0] head_time;
   logic [ID_BITS-1:0]   head_id;
   logic [ID_BITS-1:0]   count_cur;
   logic                 fits;

   cmd_type  cell_cmd;
   cell_type cell_q     [MAX_STALLS];
   logic     lt_q       [MAX_STALLS];
   cell_type left_cell  [MAX_STALLS];
   logic     left_lt    [MAX_STALLS];
   cell_type right_cell [MAX_STALLS];
   logic     right_lt   [MAX_STALLS];
   logic [MAX_STALLS-1:0] valid_vec;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign exec_go    = (state_ff == ST_EXEC) && out_free;

   // a restart sees the row as freshly reset
   assign head_time = req_data.restart ? '0 : cell_q[0].busy_until;
   assign head_id   = req_data.restart ? ONE_ID : cell_q[0].id;
   assign count_cur = req_data.restart ? ONE_ID : open_count_ff;
   assign fits      = head_time < req_data.start_time;

   always_comb begin
      pend_cmd_in   = pend_cmd_ff;
      pend_rsp_in   = pend_rsp_ff;
      open_count_in = open_count_ff;
      if (req_accept) begin
         pend_cmd_in.busy_until = req_data.end_time;
         if (fits) begin
            // earliest stall is free: reuse it
            pend_cmd_in.op         = OP_REPLACE;
            pend_cmd_in.id         = head_id;
            pend_rsp_in.stall_id   = head_id;
            pend_rsp_in.overflow   = 1'b0;
            open_count_in          = count_cur;
         end else if (count_cur < MAX_ID) begin
            // open one more stall
            pend_cmd_in.op         = OP_INSERT;
            pend_cmd_in.id         = count_cur + ONE_ID;
            pend_rsp_in.stall_id   = count_cur + ONE_ID;
            pend_rsp_in.overflow   = 1'b0;
            open_count_in          = count_cur + ONE_ID;
         end else begin
            // all stalls taken, interval dropped
            pend_cmd_in.op         = OP_HOLD;
            pend_cmd_in.id         = '0;
            pend_rsp_in.stall_id   = '0;
            pend_rsp_in.overflow   = 1'b1;
            open_count_in          = count_cur;
         end
         pend_rsp_in.stalls_in_use = open_count_in;
      end
   end

   // command to the row: clear on restart, run the pending update once the result can go
   always_comb begin
      cell_cmd    = pend_cmd_ff;
      cell_cmd.op = OP_HOLD;
      if (req_accept && req_data.restart) begin
         cell_cmd.op = OP_CLEAR;
      end else if (exec_go) begin
         cell_cmd.op = pend_cmd_ff.op;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = exec_go || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = exec_go ? pend_rsp_ff : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         open_count_ff <= ONE_ID;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         open_count_ff <= open_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_cmd_ff <= pend_cmd_in;
      pend_rsp_ff <= pend_rsp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sorted row of stall cells, head at index 0
   for (genvar g = 0; g < MAX_STALLS; g++) begin : g_row
      if (g == 0) begin : g_first
         assign left_cell[g] = '0;
         assign left_lt[g]   = 1'b1;
      end else begin : g_mid_left
         assign left_cell[g] = cell_q[g-1];
         assign left_lt[g]   = lt_q[g-1];
      end
      if (g == MAX_STALLS - 1) begin : g_last
         assign right_cell[g] = '0;
         assign right_lt[g]   = 1'b0;
      end else begin : g_mid_right
         assign right_cell[g] = cell_q[g+1];
         assign right_lt[g]   = lt_q[g+1];
      end
      assign valid_vec[g] = cell_q[g].valid;

      gisa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .is_head    (g == 0),
         .cmd        (cell_cmd),
         .left_cell  (left_cell[g]),
         .left_lt    (left_lt[g]),
         .right_cell (right_cell[g]),
         .right_lt   (right_lt[g]),
         .cell_q     (cell_q[g]),
         .lt         (lt_q[g])
      );
   end

   // head of the row always holds an open stall
   `GISA_ASSERT_NOW(a_head_valid, 1'b1, cell_q[0].valid, "head cell empty")
   // stall count stays within the row
   `GISA_ASSERT_NOW(a_count_range, 1'b1,
      (open_count_ff >= ONE_ID) && (open_count_ff <= MAX_ID), "stall count out of range")
   // between requests the row holds exactly the open stalls
   `GISA_ASSERT_NOW(a_row_fill, state_ff == ST_IDLE,
      $countones(valid_vec) == int'(open_count_ff), "row fill differs from stall count")
   // an accepted request is held off the input until its result is written
   `GISA_ASSERT_NEXT(a_accept_exec, req_accept, state_ff == ST_EXEC && req_stall,
      "accepted request not in execution")

endmodule

@@ tb/tb.sv @@
// self-checking testbench of the greedy interval stall allocator
// holds its own stall predictor in a scoreboard class; depends on gisa_pkg and the top level
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gisa_pkg::*;

   localparam int unsigned TIME_MAX = (1 << TIME_BITS) - 1;

   // predicts the stall choice of every accepted request and checks the results in order
   class stall_scoreboard;
      logic [TIME_BITS-1:0] stall_free_at[MAX_STALLS];
      int                   stalls_open;
      rsp_type              expected_q[$];
      int                   mismatches;
      int                   results_checked;
      int                   overflows_seen;
      int                   restarts_seen;
      int                   peak_stalls;

      function void clear_stalls();
         foreach (stall_free_at[i]) stall_free_at[i] = '0;
         stalls_open = 1;
      endfunction

      function new();
         clear_stalls();
         mismatches = 0;
         results_checked = 0;
         overflows_seen = 0;
         restarts_seen = 0;
         peak_stalls = 1;
      endfunction

      // earliest free stall, lowest id on a tie; a new stall when it is not strictly free
      function rsp_type place_interval(req_type r);
         int      earliest;
         rsp_type res;
         if (r.restart) begin
            clear_stalls();
            restarts_seen++;
         end
         earliest = 0;
         for (int i = 1; i < stalls_open; i++) begin
            if (stall_free_at[i] < stall_free_at[earliest]) earliest = i;
         end
         res = '0;
         if (stall_free_at[earliest] < r.start_time) begin
            stall_free_at[earliest] = r.end_time;
            res.stall_id = ID_BITS'(earliest + 1);
         end else if (stalls_open < MAX_STALLS) begin
            stall_free_at[stalls_open] = r.end_time;
            stalls_open++;
            res.stall_id = ID_BITS'(stalls_open);
         end else begin
            res.overflow = 1'b1;
            overflows_seen++;
         end
         res.stalls_in_use = ID_BITS'(stalls_open);
         if (stalls_open > peak_stalls) peak_stalls = stalls_open;
         return res;
      endfunction

      function void note_request(req_type r);
         expected_q = {expected_q, place_interval(r)};
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result with no request outstanding: %p", got);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (got.stall_id !== want.stall_id) begin
            $error("stall_id expected %0d actual %0d", want.stall_id, got.stall_id);
            mismatches++;
         end
         if (got.stalls_in_use !== want.stalls_in_use) begin
            $error("stalls_in_use expected %0d actual %0d", want.stalls_in_use,
                   got.stalls_in_use);
            mismatches++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow expected %0d actual %0d", want.overflow, got.overflow);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   stall_scoreboard sb;

   // quiet: no idling on either side for the final stretch
   bit quiet = 1'b0;
   // long receiver hold-offs asked by the sender side, served by the receiver process
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int rsp_idle_left = 0;
   int requests_sent = 0;
   int batches = 0;

   always #5 clock = ~clock;

   greedy_interval_stall_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // receiver: checks each accepted result, then decides whether to stall the next cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_left > 0) begin
            // long hold-off in progress, counted here in cycles
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = 119;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_left > 0) begin
            rsp_idle_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            // burst of stalled cycles of random length
            rsp_idle_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // limit on the whole run
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   function automatic logic [TIME_BITS-1:0] clamp_time(longint unsigned t);
      return (t > TIME_MAX) ? TIME_BITS'(TIME_MAX) : TIME_BITS'(t);
   endfunction

   // holds one request until it is taken, then notes it for prediction
   task automatic offer_request(input logic restart, input logic [TIME_BITS-1:0] start_t,
                                input logic [TIME_BITS-1:0] end_t);
      req_type r;
      r.restart = restart;
      r.start_time = start_t;
      r.end_time = end_t;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      requests_sent++;
      // random sender gap, none in the quiet stretch
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // sender holds back until every outstanding request has produced its result
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // well-formed batch: ascending starts, short intervals, so stalls get reused
   task automatic sparse_batch(input int count);
      longint unsigned t;
      longint unsigned prev_end;
      logic [TIME_BITS-1:0] s;
      case ($urandom_range(0, 3))
         0: t = 0;
         1: t = TIME_MAX - $urandom_range(0, 2000);
         default: t = $urandom_range(0, TIME_MAX);
      endcase
      prev_end = t;
      batches++;
      for (int i = 0; i < count; i++) begin
         t += $urandom_range(0, 40);
         // sometimes start exactly when the previous interval ends
         if ($urandom_range(0, 7) == 0 && prev_end >= t) t = prev_end;
         s = clamp_time(t);
         prev_end = clamp_time(longint'(s) + $urandom_range(0, 90));
         offer_request(i == 0 ? ($urandom_range(0, 9) != 0) : 1'b0, s,
                       TIME_BITS'(prev_end));
      end
   endtask

   // heavily overlapping batch that runs every stall open and then overflows
   task automatic dense_batch(input int count);
      longint unsigned t;
      t = $urandom_range(0, TIME_MAX - 1000);
      batches++;
      for (int i = 0; i < count; i++) begin
         t += $urandom_range(0, 2);
         offer_request(i == 0, clamp_time(t),
                       clamp_time(t + $urandom_range(5000, 300000)));
      end
   endtask

   // broken batch: starts out of order in a narrow window
   task automatic shuffled_batch(input int count);
      int unsigned base;
      logic [TIME_BITS-1:0] s;
      base = $urandom_range(0, TIME_MAX - 500);
      batches++;
      for (int i = 0; i < count; i++) begin
         s = TIME_BITS'(base + $urandom_range(0, 400));
         offer_request(i == 0, s, clamp_time(longint'(s) + $urandom_range(0, 300)));
      end
   endtask

   // noise: any value of every field
   task automatic noise_requests(input int count);
      for (int i = 0; i < count; i++) begin
         offer_request($urandom_range(0, 7) == 0, TIME_BITS'($urandom()),
                       TIME_BITS'($urandom()));
      end
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: equal times, reuse, end below start, field extremes, restarts
      offer_request(1'b1, 20'd0, 20'd0);              // busy time equals start, new stall
      offer_request(1'b0, 20'd1, 20'd5);              // stall one free
      offer_request(1'b0, 20'd5, 20'd9);
      offer_request(1'b0, 20'd5, 20'd20);             // earliest equals start again
      offer_request(1'b0, 20'd6, 20'd0);              // end before start
      offer_request(1'b0, TIME_BITS'(TIME_MAX), TIME_BITS'(TIME_MAX));
      offer_request(1'b0, TIME_BITS'(TIME_MAX), 20'd0);
      offer_request(1'b0, 20'd0, TIME_BITS'(TIME_MAX)); // out of order
      offer_request(1'b1, TIME_BITS'(TIME_MAX), TIME_BITS'(TIME_MAX));
      offer_request(1'b1, 20'd0, 20'd7);               // back-to-back restarts
      offer_request(1'b0, 20'd0, 20'd0);
      offer_request(1'b1, 20'd1, 20'h55555);
      offer_request(1'b0, 20'd2, 20'hAAAAA);
      offer_request(1'b0, 20'hAAAAA, 20'h55555);
      offer_request(1'b0, 20'h55555, 20'hFFFFE);
      wait_drained();

      // random batches, mostly well formed; two long receiver hold-offs on the way
      while (requests_sent < 1250) begin
         if (requests_sent > 300 && hold_asked == 0) hold_asked = 1;
         if (requests_sent > 800 && hold_asked == 1) hold_asked = 2;
         case ($urandom_range(0, 9))
            0:       dense_batch($urandom_range(66, 80));
            1:       shuffled_batch($urandom_range(3, 20));
            2:       noise_requests($urandom_range(2, 12));
            default: sparse_batch($urandom_range(4, 40));
         endcase
         if ($urandom_range(0, 19) == 0) wait_drained();
      end

      // final stretch without any idling
      wait_drained();
      quiet = 1'b1;
      dense_batch(70);
      while (requests_sent < 1400) sparse_batch($urandom_range(4, 30));

      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d requests in %0d batches, %0d restarts, %0d overflows",
               requests_sent, batches, sb.restarts_seen, sb.overflows_seen);
      $display("peak of %0d open stalls, %0d results checked, %0d mismatches",
               sb.peak_stalls, sb.results_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
